/* rtl/stoi_pkg.sv */
// Shared types, character codes and helpers for the string-to-integer parser.
`default_nettype none

package stoi_pkg;

  // Saturation limit of the consumed-character count and the output field ceiling
  localparam int unsigned OFFSET_LIMIT_DEFAULT = 32'd65535;
  localparam logic [15:0] END_OFFSET_MAX       = 16'hFFFF;

  // Configuration register indexes
  localparam logic CFG_NUMBER_BASE = 1'b0;
  localparam logic CFG_SIGNED_MODE = 1'b1;

  // Radix codes
  localparam logic [4:0] BASE_AUTO = 5'd0;
  localparam logic [4:0] BASE_OCT  = 5'd8;
  localparam logic [4:0] BASE_DEC  = 5'd10;
  localparam logic [4:0] BASE_HEX  = 5'd16;

  // Character codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LX    = 8'h78;

  // Value returned for a byte that is no hex digit
  localparam logic [4:0] NOT_DIGIT = 5'd16;

  typedef enum logic [2:0] {
    PH_SIGN,
    PH_FIRST,
    PH_ZERO,
    PH_X,
    PH_DIGITS,
    PH_DONE
  } phase_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_char;
  } char_word_t;

  typedef struct packed {
    logic [63:0] value;
    logic [15:0] end_offset;
  } result_word_t;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    begin
      d = 8'd16;
      if (c >= CH_0 && c <= CH_9) begin
        d = c - CH_0;
      end else if (c >= CH_LA && c <= CH_LF) begin
        d = c - CH_LA + 8'd10;
      end else if (c >= CH_UA && c <= CH_UF) begin
        d = c - CH_UA + 8'd10;
      end
      return d[4:0];
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/string_to_integer_parser.sv */
// Top level of the string-to-integer parser: character stage, result stage, output register.
`default_nettype none

// Parses one string, delivered one byte per word on the char channel, into a
// 64-bit integer in the manner of strtol/strtoul. The word flagged last_char
// closes the string and yields one result word: the value as a raw two's
// complement pattern and the number of characters consumed (optional minus,
// prefix and digits), saturating at OFFSET_LIMIT and at 65535. Other words
// yield nothing. Whitespace and plus are not skipped. With number_base 0 the
// radix is taken from the prefix (0x hex, 0 octal, else decimal); with 16 the
// 0x prefix is skipped. The block takes one character per clock cycle, but a
// closing character waits while the result stage is full and cannot pass its
// result on. The character stage's phase and accumulator update (one 64-bit
// by 5-bit multiply-add) is combinational. After its closing byte is accepted
// into the input register, a result moves into the result stage, then into
// the output register that drives result_valid. All three stages hold a word
// each, so input continues while a result waits for result_ready. number_base
// is latched at the first character after the optional minus; signed_mode is
// applied in the result stage. Write configuration only while no string is
// in flight.
// There is no clearing pass after reset.
module string_to_integer_parser
  import stoi_pkg::*;
#(
  parameter int unsigned OFFSET_LIMIT = OFFSET_LIMIT_DEFAULT
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // character channel
  input  wire logic         char_valid,
  output logic              char_ready,
  input  wire char_word_t   char_word,
  // result channel
  output logic              result_valid,
  input  wire logic         result_ready,
  output result_word_t      result_word,
  // configuration write port
  input  wire logic         cfg_we,
  input  wire logic         cfg_index,
  input  wire logic [4:0]   cfg_data
);

  // Effective count ceiling: the output field cannot show more than 65535
  localparam logic [15:0] CNT_MAX =
    (OFFSET_LIMIT > 32'(END_OFFSET_MAX)) ? END_OFFSET_MAX : 16'(OFFSET_LIMIT);

  // Configuration registers
  logic [4:0] number_base;
  logic       signed_mode;

  // Input register
  logic       a_valid;
  char_word_t a_word;

  // Parse state, owned by the character stage
  phase_t      phase, phase_next;
  logic [63:0] accumulator, accumulator_next;
  logic        is_negative, is_negative_next;
  logic [15:0] consumed_count, consumed_count_next;
  logic [4:0]  active_base, active_base_next;

  // Result stage: raw accumulator, sign and count of a closed string
  logic        b_valid;
  logic [63:0] b_accumulator;
  logic        b_negative;
  logic [15:0] b_count;

  // Handshake between stages
  logic c_ready, b_ready, a_advance, b_advance;

  assign c_ready    = !result_valid || result_ready;
  assign b_ready    = !b_valid || c_ready;
  assign b_advance  = b_valid && c_ready;
  // A non-final character never waits; the final one needs room in the result stage
  assign a_advance  = a_valid && (!a_word.last_char || b_ready);
  assign char_ready = !a_valid || a_advance;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= BASE_AUTO;
      signed_mode <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NUMBER_BASE: number_base <= cfg_data;
        CFG_SIGNED_MODE: signed_mode <= cfg_data[0];
        default:         number_base <= number_base;
      endcase
    end
  end

  // Input register: load on accept, drop when the character stage consumes it
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (char_ready) begin
      a_valid <= char_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (char_ready && char_valid) begin
      a_word <= char_word;
    end
  end

  // Character decode shared by next-state and datapath logic
  logic [7:0]  ch;
  logic [4:0]  dv;
  logic        is_minus, is_x, is_octal;
  logic        first_zero;
  logic [4:0]  first_base;
  logic [4:0]  feed_base;
  logic        feed_ok;
  logic [63:0] mac;
  logic [1:0]  cnt_add;
  logic [16:0] cnt_sum;

  assign ch         = a_word.character;
  assign dv         = digit_value(ch);
  assign is_minus   = (ch == CH_MINUS);
  assign is_x       = (ch == CH_LX) || (ch == CH_UX);
  assign is_octal   = (ch >= CH_0) && (ch <= CH_7);
  // A leading zero may open a prefix when the radix is automatic or hex
  assign first_zero = ((number_base == BASE_AUTO) || (number_base == BASE_HEX)) &&
                      (ch == CH_0);
  assign first_base = (number_base == BASE_AUTO) ? BASE_DEC : number_base;

  // Radix that the current character is weighed in
  always_comb begin
    unique case (phase)
      PH_SIGN, PH_FIRST: feed_base = first_base;
      PH_ZERO:           feed_base = (active_base == BASE_AUTO) ?
                                     (is_octal ? BASE_OCT : BASE_DEC) : active_base;
      PH_X:              feed_base = BASE_HEX;
      default:           feed_base = active_base;
    endcase
  end

  assign feed_ok = (dv < feed_base);
  assign mac     = accumulator * {59'd0, feed_base} + {59'd0, dv};

  // Next phase
  always_comb begin
    unique case (phase)
      PH_SIGN: begin
        if (is_minus) begin
          phase_next = PH_FIRST;
        end else if (first_zero) begin
          phase_next = PH_ZERO;
        end else begin
          phase_next = feed_ok ? PH_DIGITS : PH_DONE;
        end
      end
      PH_FIRST: begin
        if (first_zero) begin
          phase_next = PH_ZERO;
        end else begin
          phase_next = feed_ok ? PH_DIGITS : PH_DONE;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          phase_next = PH_X;
        end else begin
          phase_next = feed_ok ? PH_DIGITS : PH_DONE;
        end
      end
      PH_X, PH_DIGITS: phase_next = feed_ok ? PH_DIGITS : PH_DONE;
      default:         phase_next = PH_DONE;
    endcase
  end

  // Datapath updates per phase
  always_comb begin
    accumulator_next = accumulator;
    active_base_next = active_base;
    is_negative_next = is_negative;
    cnt_add          = 2'd0;
    unique case (phase)
      PH_SIGN, PH_FIRST: begin
        if ((phase == PH_SIGN) && is_minus) begin
          is_negative_next = 1'b1;
          cnt_add          = 2'd1;
        end else if (first_zero) begin
          active_base_next = number_base;
          cnt_add          = 2'd1;
        end else begin
          active_base_next = first_base;
          if (feed_ok) begin
            accumulator_next = mac;
            cnt_add          = 2'd1;
          end
        end
      end
      PH_ZERO: begin
        if (!is_x) begin
          active_base_next = feed_base;
          if (feed_ok) begin
            accumulator_next = mac;
            cnt_add          = 2'd1;
          end
        end
      end
      PH_X: begin
        // The x and the first hex digit are consumed together
        if (feed_ok) begin
          active_base_next = BASE_HEX;
          accumulator_next = mac;
          cnt_add          = 2'd2;
        end
      end
      PH_DIGITS: begin
        if (feed_ok) begin
          accumulator_next = mac;
          cnt_add          = 2'd1;
        end
      end
      default: begin
        accumulator_next = accumulator;
      end
    endcase
  end

  // Saturating count; the stored count never exceeds the ceiling
  assign cnt_sum             = {1'b0, consumed_count} + {15'd0, cnt_add};
  assign consumed_count_next = (cnt_sum > {1'b0, CNT_MAX}) ? CNT_MAX : cnt_sum[15:0];

  // Parse state: advance per character, clear after the final one
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SIGN;
      accumulator    <= '0;
      is_negative    <= 1'b0;
      consumed_count <= '0;
      active_base    <= BASE_AUTO;
    end else if (a_advance) begin
      if (a_word.last_char) begin
        phase          <= PH_SIGN;
        accumulator    <= '0;
        is_negative    <= 1'b0;
        consumed_count <= '0;
        active_base    <= BASE_AUTO;
      end else begin
        phase          <= phase_next;
        accumulator    <= accumulator_next;
        is_negative    <= is_negative_next;
        consumed_count <= consumed_count_next;
        active_base    <= active_base_next;
      end
    end
  end

  // Result stage: hold the closed string's raw figures
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (a_advance && a_word.last_char) begin
      b_valid <= 1'b1;
    end else if (b_advance) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance && a_word.last_char) begin
      b_accumulator <= accumulator_next;
      b_negative    <= is_negative_next;
      b_count       <= consumed_count_next;
    end
  end

  // Absolute value then optional negation collapses to one conditional negate
  logic        negate;
  logic [63:0] value_final;

  assign negate      = signed_mode && (b_accumulator[63] ^ b_negative);
  assign value_final = negate ? (64'd0 - b_accumulator) : b_accumulator;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (c_ready) begin
      result_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance) begin
      result_word.value      <= value_final;
      result_word.end_offset <= b_count;
    end
  end

endmodule

`default_nettype wire

/* rtl/stoi_checker.sv */
// Port-level checker for the string-to-integer parser and its bind.
`default_nettype none

module stoi_checker
  import stoi_pkg::*;
(
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         char_valid,
  input wire logic         char_ready,
  input wire char_word_t   char_word,
  input wire logic         result_valid,
  input wire logic         result_ready,
  input wire result_word_t result_word
);

  // Strings closed on input but not yet delivered
  logic [1:0] owed;
  logic       close_in, close_out;

  assign close_in  = char_valid && char_ready && char_word.last_char;
  assign close_out = result_valid && result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= 2'd0;
    end else if (close_in && !close_out) begin
      owed <= owed + 2'd1;
    end else if (close_out && !close_in) begin
      owed <= owed - 2'd1;
    end
  end

  // A waiting result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result_word))
    else $error("result word changed while stalled");

  // No result without a closed string behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> owed != 2'd0)
    else $error("result without a closing character");

  // The three stages bound the strings in flight
  a_depth: assert property (@(posedge clk) disable iff (rst)
    owed == 2'd3 |-> !close_in || close_out)
    else $error("more strings in flight than stages");

  // Nothing consumed means a zero value
  a_zero_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result_word.end_offset == 16'd0) |-> result_word.value == 64'd0)
    else $error("nonzero value with no characters consumed");

endmodule

bind string_to_integer_parser stoi_checker u_stoi_checker (
  .clk          (clk),
  .rst          (rst),
  .char_valid   (char_valid),
  .char_ready   (char_ready),
  .char_word    (char_word),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result_word  (result_word)
);

`default_nettype wire

/* sim/string_to_integer_parser_tb.sv */
// Testbench for string_to_integer_parser: random strings, a shadow parser and in-order result checks.
`timescale 1ns / 100ps

module string_to_integer_parser_tb;
  import stoi_pkg::*;

  typedef logic [7:0] byte_str_t[$];

  // Cycles with no word moving on either channel before the run is called hung
  localparam int STALL_LIMIT = 2000;
  // Margin before touching registers once the last result is back
  localparam int SETTLE_CYCLES = 8;
  // Long enough to wrap the 64-bit accumulator many times over
  localparam int LONG_DIGITS = 200;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         char_valid = 1'b0;
  logic         char_ready;
  char_word_t   char_word = '0;
  logic         result_valid;
  logic         result_ready = 1'b0;
  result_word_t result_word;
  logic         cfg_we = 1'b0;
  logic         cfg_index = CFG_NUMBER_BASE;
  logic [4:0]   cfg_data = '0;

  // Words waiting to go out, and results the shadow parser has worked out
  char_word_t   pending_chars[$];
  result_word_t expected_numbers[$];

  // Register copies, written together with the block's registers
  logic [4:0]   cfg_base = BASE_AUTO;
  logic         cfg_signed = 1'b1;

  // Shadow parser state
  phase_t       parse_phase;
  logic [63:0]  parse_acc;
  logic         parse_neg;
  logic [15:0]  parse_used;
  logic [4:0]   parse_base;

  int           mismatches = 0;
  int           idle_odds = 0;  // 0 turns idling off, else one burst start in idle_odds
  int           idle_left = 0;
  int           stall_left = 0;
  int           quiet_cycles = 0;

  string_to_integer_parser DUT (
    .clk          (clk),
    .rst          (rst),
    .char_valid   (char_valid),
    .char_ready   (char_ready),
    .char_word    (char_word),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_word  (result_word),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow parser
  // ---------------------------------------------------------------------------

  // Hex digit value of a byte; NOT_DIGIT for anything else
  function automatic logic [4:0] char_digit(input logic [7:0] c);
    if (c >= CH_0 && c <= CH_9) return 5'(c - CH_0);
    if (c >= CH_LA && c <= CH_LF) return 5'(c - CH_LA + 8'd10);
    if (c >= CH_UA && c <= CH_UF) return 5'(c - CH_UA + 8'd10);
    return NOT_DIGIT;
  endfunction

  function automatic void clear_parse();
    parse_phase = PH_SIGN;
    parse_acc   = '0;
    parse_neg   = 1'b0;
    parse_used  = '0;
    parse_base  = BASE_AUTO;
  endfunction

  // Saturating count of consumed characters
  function automatic void bump_used();
    if (32'(parse_used) < OFFSET_LIMIT_DEFAULT) parse_used = parse_used + 16'd1;
  endfunction

  // Take a digit of the active radix or close the number. With a radix above
  // sixteen every byte passes, since a non-digit still rates below the radix.
  function automatic void feed_digit(input logic [7:0] c);
    logic [4:0] d;
    d = char_digit(c);
    if (d < parse_base) begin
      parse_acc = parse_acc * 64'(parse_base) + 64'(d);
      bump_used();
      parse_phase = PH_DIGITS;
    end else begin
      parse_phase = PH_DONE;
    end
  endfunction

  // First character after the optional minus: latch the radix here
  function automatic void take_first(input logic [7:0] c);
    parse_base = cfg_base;
    if ((parse_base == BASE_AUTO || parse_base == BASE_HEX) && c == CH_0) begin
      bump_used();
      parse_phase = PH_ZERO;
    end else begin
      if (parse_base == BASE_AUTO) parse_base = BASE_DEC;
      feed_digit(c);
    end
  endfunction

  // Advance the shadow parser by one accepted word; a closing word queues a result
  function automatic void parse_char(input char_word_t w);
    logic [63:0]  v;
    result_word_t r;
    case (parse_phase)
      PH_SIGN: begin
        if (w.character == CH_MINUS) begin
          parse_neg = 1'b1;
          bump_used();
          parse_phase = PH_FIRST;
        end else begin
          take_first(w.character);
        end
      end
      PH_FIRST: take_first(w.character);
      PH_ZERO: begin
        if (w.character == CH_LX || w.character == CH_UX) begin
          parse_phase = PH_X;
        end else begin
          if (parse_base == BASE_AUTO)
            parse_base = (w.character >= CH_0 && w.character <= CH_7) ? BASE_OCT : BASE_DEC;
          feed_digit(w.character);
        end
      end
      PH_X: begin
        // the x only counts once a hex digit follows it
        if (char_digit(w.character) != NOT_DIGIT) begin
          parse_base = BASE_HEX;
          bump_used();
          feed_digit(w.character);
        end else begin
          parse_phase = PH_DONE;
        end
      end
      PH_DIGITS: feed_digit(w.character);
      default: ;
    endcase
    if (w.last_char) begin
      v = parse_acc;
      if (cfg_signed) begin
        // absolute value as a signed long first, then apply the minus
        if (v[63]) v = 64'd0 - v;
        if (parse_neg) v = 64'd0 - v;
      end
      r.value      = v;
      r.end_offset = parse_used;
      expected_numbers.push_back(r);
      clear_parse();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  function automatic void note_error(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic void check_result(input result_word_t got);
    result_word_t want;
    if (expected_numbers.size() == 0) begin
      note_error($sformatf("result with none expected: value %h end_offset %0d",
                           got.value, got.end_offset));
      return;
    end
    want = expected_numbers.pop_front();
    if (got.value !== want.value)
      note_error($sformatf("value: expected %h, got %h", want.value, got.value));
    if (got.end_offset !== want.end_offset)
      note_error($sformatf("end_offset: expected %0d, got %0d",
                           want.end_offset, got.end_offset));
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] digit_char(input int unsigned v);
    if (v < 10) return CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? CH_LA : CH_UA) + 8'(v - 10);
  endfunction

  function automatic byte_str_t text_bytes(input string t);
    byte_str_t s;
    s = {};
    for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
    return s;
  endfunction

  // Split a string into words and flag the closing one
  function automatic void queue_string(input byte_str_t s);
    char_word_t w;
    for (int i = 0; i < s.size(); i++) begin
      w.character = s[i];
      w.last_char = (i == s.size() - 1);
      pending_chars.push_back(w);
    end
  endfunction

  // Mostly well-formed numbers for the given radix setting: optional minus,
  // optional prefix, digits of the radix, sometimes trailing bytes. The rest
  // is raw noise and broken prefixes.
  function automatic byte_str_t random_string(input logic [4:0] base);
    byte_str_t   s;
    int unsigned radix;
    int unsigned n;
    s = {};
    case ($urandom_range(0, 9))
      0: begin
        n = $urandom_range(1, 8);
        repeat (n) s.push_back(8'($urandom_range(0, 255)));
        return s;
      end
      1: begin
        case ($urandom_range(0, 3))
          0: s.push_back(CH_MINUS);
          1: begin
            s.push_back(CH_0);
            s.push_back(CH_LX);
          end
          2: begin
            s.push_back(CH_MINUS);
            s.push_back(CH_MINUS);
            s.push_back(digit_char(1));
          end
          default: begin
            // 0X then a byte from 'g' up, never a hex digit
            s.push_back(CH_0);
            s.push_back(CH_UX);
            s.push_back(8'($urandom_range(8'h67, 8'hFF)));
          end
        endcase
        return s;
      end
      default: ;
    endcase
    if ($urandom_range(0, 2) == 0) s.push_back(CH_MINUS);
    radix = (base == BASE_AUTO) ? 10 : base;
    if ((base == BASE_AUTO || base == BASE_HEX) && $urandom_range(0, 1) == 0) begin
      s.push_back(CH_0);
      if (base == BASE_HEX || $urandom_range(0, 1) == 0) begin
        s.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
        radix = 16;
      end else begin
        radix = 8;
      end
    end
    if (radix > 16) radix = 16;
    // now and then enough digits to wrap the 64-bit accumulator
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 28) : $urandom_range(0, 6);
    repeat (n) s.push_back(digit_char($urandom_range(0, radix - 1)));
    if (s.size() == 0 || $urandom_range(0, 2) == 0)
      repeat ($urandom_range(1, 3)) s.push_back(8'($urandom_range(0, 255)));
    return s;
  endfunction

  task automatic write_cfg(input logic idx, input logic [4:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NUMBER_BASE) cfg_base = data;
    else cfg_signed = data[0];
    @(negedge clk);
  endtask

  // Hold until every word is out and every result is back, then let the
  // pipeline empty before anything touches the registers
  task automatic drain();
    @(negedge clk);
    while (pending_chars.size() != 0 || char_valid || expected_numbers.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one word per handshake, idle bursts only between words
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      idle_left = 0;
      clear_parse();
    end else begin
      if (char_valid && char_ready) parse_char(char_word);
      if (!char_valid || char_ready) begin
        if (idle_left > 0) begin
          idle_left--;
          char_valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          // start an idle burst that includes this cycle
          idle_left = $urandom_range(0, 8);
          char_valid <= 1'b0;
        end else if (pending_chars.size() != 0) begin
          char_word  <= pending_chars.pop_front();
          char_valid <= 1'b1;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result, stall the result channel in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_valid && result_ready) check_result(result_word);
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        stall_left = $urandom_range(0, 8);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if (rst || (char_valid && char_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed strings, random phases, long-string tail
  // ---------------------------------------------------------------------------
  initial begin
    byte_str_t  s;
    logic [4:0] base;
    int         used;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part with auto radix and signed results
    idle_odds = 4;
    write_cfg(CFG_NUMBER_BASE, BASE_AUTO);
    write_cfg(CFG_SIGNED_MODE, 5'd1);
    queue_string(text_bytes("-"));      // minus alone still counts as consumed
    queue_string(text_bytes("0xg"));    // prefix without digit: only the 0 counts
    queue_string(text_bytes("017"));    // octal by prefix
    queue_string(text_bytes("-0x1F"));  // hex by prefix, negated
    queue_string(text_bytes("09"));     // leading 0, non-octal digit: decimal
    queue_string(text_bytes("z"));      // no digits at all
    s = {8'h00};                        // lowest byte, alone
    queue_string(s);
    s = {CH_7, 8'hFF};                  // highest byte after a digit
    queue_string(s);
    s = {CH_0 + 8'd5, 8'h00, CH_0 + 8'd3};  // zero byte ends the number
    queue_string(s);
    drain();

    // Random phases over radix settings, extremes among them
    for (int p = 0; p < 14; p++) begin
      case (p)
        0, 8:    base = BASE_AUTO;
        1, 9:    base = BASE_DEC;
        2, 10:   base = BASE_HEX;
        3:       base = BASE_OCT;
        4:       base = 5'd2;
        5:       base = 5'd1;
        6:       base = 5'd31;
        7:       base = 5'd17;
        default: base = 5'($urandom_range(0, 31));
      endcase
      write_cfg(CFG_NUMBER_BASE, base);
      write_cfg(CFG_SIGNED_MODE, 5'((p % 2 == 0) != (p >= 8)));
      idle_odds = (p % 5 == 4) ? 0 : $urandom_range(2, 12);
      used = 0;
      while (used < 50) begin
        s = random_string(base);
        queue_string(s);
        used += s.size();
      end
      drain();
    end

    // Tail without idling: one long negative decimal string, then a few more
    idle_odds = 0;
    write_cfg(CFG_NUMBER_BASE, BASE_DEC);
    write_cfg(CFG_SIGNED_MODE, 5'd1);
    s = {CH_MINUS};
    repeat (LONG_DIGITS) s.push_back(digit_char(9));
    queue_string(s);
    repeat (20) queue_string(random_string(BASE_DEC));
    drain();

    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* string_to_integer_parser.f */
rtl/stoi_pkg.sv
rtl/string_to_integer_parser.sv
rtl/stoi_checker.sv
sim/string_to_integer_parser_tb.sv
